// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types, codes and default sizes for the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DATA_W       = 32;
    localparam int FILL_W       = 9;
    localparam int STAT_W       = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [STAT_W-1:0]        status;
        logic [FILL_W-1:0]        fill_count;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_LAST,
        ST_POP_TAKE,
        ST_DN_L,
        ST_DN_R,
        ST_DN_C,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue with push and pop-maximum operations.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_* is a push (kind 0, value) or a pop (kind 1).
// Every input beat yields exactly one result beat on m_*: the removed maximum
// on a successful pop (zero otherwise), a status code (ok, push refused since
// full, pop refused since empty) and the element count after the operation.
// The heap lives in one RAM with a registered read port; a small sequencer
// walks the tree one level at a time through that single read port.
// A push climbs the tree a level at a time while it is strictly greater than
// its parent, stopping at the root; a pop moves the last element to the root
// and sinks it a level at a time while a child is strictly greater, stopping
// at a leaf; a pop that empties the queue skips the sift, and a refused
// operation goes straight to the result.
// One item is in work at a time: s_ready is high only while the sequencer is
// idle, so the next beat is taken in the cycle after the result is loaded. The
// result is held in an output register; if the receiver stalls, a finished
// item waits there and the sequencer waits with the next result.
// Reset empties the queue at once (the count is cleared; no RAM sweep).
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire mhpq_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output mhpq_pkg::out_t      m_data
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 1;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     m_valid_reg, m_valid_next;
    out_t                     m_data_reg, m_data_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic signed [DATA_W-1:0] left_reg, left_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic [STAT_W-1:0]        stat_reg, stat_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic [AW-1:0]            parent_idx;
    logic [IW-1:0]            left_idx;
    logic [IW-1:0]            right_idx;
    logic [IW-1:0]            cnt_ext;
    logic                     take_right;
    logic signed [DATA_W-1:0] big_val;
    logic [IW-1:0]            big_idx;
    logic                     in_beat;

    mhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_beat = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign cnt_ext    = IW'(cnt_reg);

    // Right child is taken only when it exists and is strictly greater.
    assign take_right = (right_idx < cnt_ext) && ($signed(ram_rdata) > left_reg);
    assign big_val    = take_right ? $signed(ram_rdata) : left_reg;
    assign big_idx    = take_right ? right_idx : left_idx;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        left_next    = left_reg;
        top_next     = top_reg;
        stat_next    = stat_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = v_reg;
        ram_raddr    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    top_next  = '0;
                    stat_next = STAT_OK;
                    if (s_data.kind == KIND_PUSH) begin
                        if (cnt_reg == CW'(CAPACITY)) begin
                            stat_next  = STAT_FULL;
                            state_next = ST_DONE;
                        end else begin
                            v_next     = s_data.value;
                            pos_next   = AW'(cnt_reg);
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = ST_UP_RD;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            stat_next  = STAT_EMPTY;
                            state_next = ST_DONE;
                        end else begin
                            ram_raddr  = '0;
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = ST_POP_LAST;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    ram_raddr  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                ram_we = 1'b1;
                if (v_reg > $signed(ram_rdata)) begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_LAST: begin
                // Root arrives now; fetch the last element, which is moved to the root.
                top_next   = $signed(ram_rdata);
                ram_raddr  = AW'(cnt_reg);
                state_next = ST_POP_TAKE;
            end
            ST_POP_TAKE: begin
                v_next     = $signed(ram_rdata);
                pos_next   = '0;
                state_next = (cnt_reg == '0) ? ST_DONE : ST_DN_L;
            end
            ST_DN_L: begin
                if (left_idx >= cnt_ext) begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    ram_raddr  = AW'(left_idx);
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R: begin
                left_next  = $signed(ram_rdata);
                ram_raddr  = AW'(right_idx);
                state_next = ST_DN_C;
            end
            ST_DN_C: begin
                ram_we = 1'b1;
                if (big_val > v_reg) begin
                    ram_wdata  = big_val;
                    pos_next   = AW'(big_idx);
                    state_next = ST_DN_L;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.top_value  = top_reg;
                    m_data_next.status     = stat_reg;
                    m_data_next.fill_count = FILL_W'(cnt_reg);
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        pos_reg    <= pos_next;
        v_reg      <= v_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
        stat_reg   <= stat_next;
    end

    // The element count never exceeds the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // The store is written only while sifting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_UP_RD || state_reg == ST_UP_CMP ||
                    state_reg == ST_DN_L || state_reg == ST_DN_C))
        else $error("store write outside a sift step");

    // A fresh result reports the count that the operation left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready))
        |=> (m_valid && m_data.fill_count == FILL_W'(cnt_reg)))
        else $error("result count does not match element count");

    // A pop on an empty queue is refused without touching the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_data.kind == KIND_POP && cnt_reg == '0)
        |=> (state_reg == ST_DONE && stat_reg == STAT_EMPTY && cnt_reg == '0))
        else $error("empty pop not refused");

endmodule

`default_nettype wire
